[rtl/brtc_pkg.sv]
package brtc_pkg;

    localparam int unsigned DIV_BITS       = 32;
    localparam int unsigned BITS_PER_STAGE = 4;
    localparam int unsigned DIV_STAGES     = DIV_BITS / BITS_PER_STAGE;
    localparam int unsigned N_STAGES       = 2 * DIV_STAGES;
    localparam int unsigned QUEUE_DEPTH    = 4;
    localparam int unsigned QUEUE_AW       = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] CNT_MAX    = 16'd256;
    localparam logic [4:0]  HEADS_MAX  = 5'd16;

    localparam logic [2:0] REG_SPT    = 3'd0;
    localparam logic [2:0] REG_HEADS  = 3'd1;
    localparam logic [2:0] REG_PSTART = 3'd2;
    localparam logic [2:0] REG_PSIZE  = 3'd3;
    localparam logic [2:0] REG_DRIVE  = 3'd4;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_COUNT = 2'd2
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  count_field;
        logic [31:0] linear;
    } item_t;

    typedef struct packed {
        logic [7:0] spt;
        logic [7:0] heads;
        logic       drive;
    } geom_t;

    typedef struct packed {
        logic [7:0]          rem;
        logic [DIV_BITS-1:0] work;
    } div_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] count_field;
        logic [7:0] sec_rem;
        div_t       dv;
    } stage_t;

    // Restoring division, BITS_PER_STAGE quotient bits per call.
    // The remainder stays below the divisor, so it fits in 8 bits.
    function automatic div_t div_step(div_t d, logic [7:0] divisor);
        logic [8:0] t;
        logic       q;
        div_t       r;
        r = d;
        for (int i = 0; i < BITS_PER_STAGE; i++)
        begin
            t = {r.rem, r.work[DIV_BITS-1]};
            q = (t >= {1'b0, divisor});
            r.work = {r.work[DIV_BITS-2:0], q};
            if (q)
            begin
                r.rem = 8'(t - {1'b0, divisor});
            end
            else
            begin
                r.rem = t[7:0];
            end
        end
        return r;
    endfunction

endpackage

[rtl/brtc_front.sv]
module brtc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [31:0]          start_block,
    input  logic [15:0]          block_count,
    input  logic [31:0]          partition_start,
    input  logic [31:0]          partition_size,
    input  logic                 queue_full,
    output logic                 push,
    output brtc_pkg::item_t      push_item
);

    logic            front_valid_reg;
    brtc_pkg::item_t item_reg;
    brtc_pkg::item_t item_next;
    logic            advance;
    logic [32:0]     end_sum;
    logic            range_bad;
    logic            count_bad;

    // The range check uses the exact 33-bit sum and has priority over the count check.
    always_comb
    begin
        end_sum   = {1'b0, start_block} + {17'b0, block_count};
        range_bad = end_sum > {1'b0, partition_size};
        count_bad = (block_count == 16'd0) || (block_count > brtc_pkg::CNT_MAX);
        item_next.linear      = start_block + partition_start;
        item_next.count_field = block_count[7:0];
        if (range_bad)
        begin
            item_next.status      = brtc_pkg::ST_RANGE;
            item_next.count_field = 8'd0;
        end
        else if (count_bad)
        begin
            item_next.status      = brtc_pkg::ST_COUNT;
            item_next.count_field = 8'd0;
        end
        else
        begin
            item_next.status = brtc_pkg::ST_OK;
        end
    end

    assign advance   = !front_valid_reg || !queue_full;
    assign in_stall  = front_valid_reg && queue_full;
    assign push      = front_valid_reg && !queue_full;
    assign push_item = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            front_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

[rtl/brtc_queue.sv]
module brtc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  brtc_pkg::item_t push_item,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output brtc_pkg::item_t head_item
);

    brtc_pkg::item_t                  mem [brtc_pkg::QUEUE_DEPTH];
    logic [brtc_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [brtc_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [brtc_pkg::QUEUE_AW:0]      fill_reg;
    logic                             do_push;
    logic                             do_pop;

    assign full      = fill_reg == (brtc_pkg::QUEUE_AW + 1)'(brtc_pkg::QUEUE_DEPTH);
    assign empty     = fill_reg == '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/brtc_back.sv]
module brtc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  brtc_pkg::geom_t geom,
    input  logic            queue_empty,
    input  brtc_pkg::item_t head_item,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [1:0]      status,
    output logic [7:0]      sector_field,
    output logic [7:0]      cylinder_low,
    output logic [7:0]      cylinder_high,
    output logic [3:0]      head,
    output logic            drive_bit,
    output logic [7:0]      count_field
);

    localparam int unsigned N = brtc_pkg::N_STAGES;

    brtc_pkg::stage_t s_reg  [N+1];
    brtc_pkg::stage_t s_next [N+1];
    logic [N:0]       v_reg;
    logic             advance;
    logic             ok;

    assign advance = !(v_reg[N] && out_stall);
    assign pop     = advance && !queue_empty;

    // The first half divides the linear sector by the sectors per track; the
    // second half divides that quotient by the head count.
    always_comb
    begin
        s_next[0].status      = head_item.status;
        s_next[0].count_field = head_item.count_field;
        s_next[0].sec_rem     = 8'd0;
        s_next[0].dv.rem      = 8'd0;
        s_next[0].dv.work     = head_item.linear;
        for (int k = 1; k <= N; k++)
        begin
            s_next[k] = s_reg[k-1];
            if (k <= brtc_pkg::DIV_STAGES)
            begin
                s_next[k].dv = brtc_pkg::div_step(s_reg[k-1].dv, geom.spt);
                if (k == brtc_pkg::DIV_STAGES)
                begin
                    s_next[k].sec_rem = s_next[k].dv.rem;
                    s_next[k].dv.rem  = 8'd0;
                end
            end
            else
            begin
                s_next[k].dv = brtc_pkg::div_step(s_reg[k-1].dv, geom.heads);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (advance)
        begin
            v_reg <= {v_reg[N-1:0], !queue_empty};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k <= N; k++)
            begin
                s_reg[k] <= s_next[k];
            end
        end
    end

    assign ok            = s_reg[N].status == brtc_pkg::ST_OK;
    assign out_valid     = v_reg[N];
    assign status        = s_reg[N].status;
    assign sector_field  = ok ? s_reg[N].sec_rem + 8'd1 : 8'd0;
    assign cylinder_low  = ok ? s_reg[N].dv.work[7:0] : 8'd0;
    assign cylinder_high = ok ? s_reg[N].dv.work[15:8] : 8'd0;
    assign head          = ok ? s_reg[N].dv.rem[3:0] : 4'd0;
    assign drive_bit     = ok ? geom.drive : 1'b0;
    assign count_field   = ok ? s_reg[N].count_field : 8'd0;

endmodule

[rtl/block_read_to_chs_taskfile.sv]
// Channel   Handshake              Payload
// in        in_valid / in_stall    start_block, block_count
// out       out_valid / out_stall  status, sector_field, cylinder_low, cylinder_high,
//                                  head, drive_bit, count_field
// config    APB write/read         spt, head_count, partition_start,
//                                  partition_size, drive_select
//
// One beat is accepted per cycle while in_stall is low; a beat reaches out_valid through the
// front register, the queue, the pipeline entry register and the two 8-stage divider
// pipelines, 4 quotient bits a stage.
// Reset returns the geometry to 63 sectors and 16 heads with an empty partition.
// A four-entry queue between the checking front and the divider back lets the input keep
// flowing while the output is stalled, until the queue and the front register fill.
module block_read_to_chs_taskfile (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] start_block,
    input  logic [15:0] block_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  sector_field,
    output logic [7:0]  cylinder_low,
    output logic [7:0]  cylinder_high,
    output logic [3:0]  head,
    output logic        drive_bit,
    output logic [7:0]  count_field
);

    logic [7:0]      spt_reg;
    logic [4:0]      heads_reg;
    logic [31:0]     pstart_reg;
    logic [31:0]     psize_reg;
    logic            drive_reg;
    logic            cfg_write;
    logic [2:0]      reg_index;
    brtc_pkg::geom_t geom;
    logic            queue_full;
    logic            queue_empty;
    logic            push;
    logic            pop;
    brtc_pkg::item_t push_item;
    brtc_pkg::item_t head_item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spt_reg    <= 8'd63;
            heads_reg  <= 5'd16;
            pstart_reg <= 32'd0;
            psize_reg  <= 32'd0;
            drive_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                brtc_pkg::REG_SPT:    spt_reg    <= pwdata[7:0];
                brtc_pkg::REG_HEADS:  heads_reg  <= pwdata[4:0];
                brtc_pkg::REG_PSTART: pstart_reg <= pwdata;
                brtc_pkg::REG_PSIZE:  psize_reg  <= pwdata;
                brtc_pkg::REG_DRIVE:  drive_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            brtc_pkg::REG_SPT:    prdata = {24'd0, spt_reg};
            brtc_pkg::REG_HEADS:  prdata = {27'd0, heads_reg};
            brtc_pkg::REG_PSTART: prdata = pstart_reg;
            brtc_pkg::REG_PSIZE:  prdata = psize_reg;
            brtc_pkg::REG_DRIVE:  prdata = {31'd0, drive_reg};
            default:              prdata = 32'd0;
        endcase
    end

    // A zero geometry value acts as one, and more than sixteen heads act as sixteen.
    always_comb
    begin
        geom.spt   = (spt_reg == 8'd0) ? 8'd1 : spt_reg;
        geom.drive = drive_reg;
        if (heads_reg == 5'd0)
        begin
            geom.heads = 8'd1;
        end
        else if (heads_reg > brtc_pkg::HEADS_MAX)
        begin
            geom.heads = {3'd0, brtc_pkg::HEADS_MAX};
        end
        else
        begin
            geom.heads = {3'd0, heads_reg};
        end
    end

    brtc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .start_block     (start_block),
        .block_count     (block_count),
        .partition_start (pstart_reg),
        .partition_size  (psize_reg),
        .queue_full      (queue_full),
        .push            (push),
        .push_item       (push_item)
    );

    brtc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (queue_full),
        .empty     (queue_empty),
        .head_item (head_item)
    );

    brtc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .geom          (geom),
        .queue_empty   (queue_empty),
        .head_item     (head_item),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .sector_field  (sector_field),
        .cylinder_low  (cylinder_low),
        .cylinder_high (cylinder_high),
        .head          (head),
        .drive_bit     (drive_bit),
        .count_field   (count_field)
    );

endmodule

[rtl/brtc_checker.sv]
module brtc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] status,
    input logic [7:0] sector_field,
    input logic [7:0] cylinder_low,
    input logic [7:0] cylinder_high,
    input logic [3:0] head,
    input logic       drive_bit,
    input logic [7:0] count_field
);

    logic is_ok;
    logic is_range;
    logic is_count;

    assign is_ok    = status == brtc_pkg::ST_OK;
    assign is_range = status == brtc_pkg::ST_RANGE;
    assign is_count = status == brtc_pkg::ST_COUNT;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(status) && $stable(sector_field)
            && $stable(cylinder_low) && $stable(cylinder_high) && $stable(head))
        else $error("stalled result beat changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> is_ok || is_range || is_count)
        else $error("undefined status code");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_ok |-> sector_field == 8'd0 && cylinder_low == 8'd0
            && cylinder_high == 8'd0 && head == 4'd0 && drive_bit == 1'b0
            && count_field == 8'd0)
        else $error("rejected request carries nonzero fields");

    a_sector_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_ok |-> sector_field != 8'd0)
        else $error("accepted request has sector number zero");

endmodule

bind block_read_to_chs_taskfile brtc_checker u_brtc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .sector_field  (sector_field),
    .cylinder_low  (cylinder_low),
    .cylinder_high (cylinder_high),
    .head          (head),
    .drive_bit     (drive_bit),
    .count_field   (count_field)
);
